>>> rtl/gmde_pkg.sv
// shared types, codes and field layout for the graph marker erosion block
`default_nettype none

package gmde_pkg;

  // default sizing
  localparam int MAX_NODES_DEF      = 1024;
  localparam int MAX_NEIGHBOURS_DEF = 8;

  // fixed field widths
  localparam int COORD_W  = 24;
  localparam int IDX_W    = 10;
  localparam int CNT_W    = 11;
  localparam int THR_W    = 50;
  localparam int NCOUNT_W = 4;
  localparam int SLOT_W   = 3;
  localparam int FUNC_W   = 2;

  // input tdata layout, lowest bit first
  localparam int IN_NODE_LSB   = 0;
  localparam int IN_X_LSB      = IN_NODE_LSB + IDX_W;
  localparam int IN_Y_LSB      = IN_X_LSB + COORD_W;
  localparam int IN_Z_LSB      = IN_Y_LSB + COORD_W;
  localparam int IN_MARK_LSB   = IN_Z_LSB + COORD_W;
  localparam int IN_NCOUNT_LSB = IN_MARK_LSB + 1;
  localparam int IN_SLOT_LSB   = IN_NCOUNT_LSB + NCOUNT_W;
  localparam int IN_NIDX_LSB   = IN_SLOT_LSB + SLOT_W;
  localparam int IN_BITS       = IN_NIDX_LSB + IDX_W;
  localparam int IN_DATA_W     = ((IN_BITS + 7) / 8) * 8;

  // output tdata layout, lowest bit first
  localparam int OUT_BITS   = IDX_W + 1 + 1 + CNT_W + CNT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // configuration register indexes
  localparam logic REG_NODE_COUNT   = 1'b0;
  localparam logic REG_THRESHOLD_SQ = 1'b1;

  // item kinds
  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD = 2'd0,
    FN_LINK = 2'd1,
    FN_RUN  = 2'd2,
    FN_READ = 2'd3
  } func_t;

  // node memory read address source
  typedef enum logic [1:0] {
    NA_I     = 2'd0,
    NA_LINK  = 2'd1,
    NA_BLIST = 2'd2
  } naddr_sel_t;

  // link memory read address source
  typedef enum logic {
    LA_I  = 1'b0,
    LA_NB = 1'b1
  } laddr_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic       ld_node;
    logic       ld_link;
    logic       rd_flags;
    logic       out_load;
    logic       i_clr;
    logic       i_inc;
    logic       a_clr;
    logic       a_inc;
    logic       b_clr;
    logic       b_inc;
    logic       k_clr;
    logic       k_inc;
    logic       cnt_clr;
    logic       cap_i;
    logic       cap_nb;
    logic       flag_wr;
    logic       flag_keep;
    logic       flag_border;
    logic       keep_clr;
    logic       blist_wr;
    logic       ran_set;
    naddr_sel_t naddr_sel;
    laddr_sel_t laddr_sel;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic i_in;
    logic i_last;
    logic a_done;
    logic b_done;
    logic k_done;
    logic q_marker;
    logic near;
    logic out_full;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/gmde_ctrl.sv
// sequencer for loads, reads and the two-phase erosion run
`default_nettype none

module gmde_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [gmde_pkg::FUNC_W-1:0] s_tuser,
  input  wire logic                   m_tready,
  input  wire gmde_pkg::sts_t         sts,
  output gmde_pkg::cmd_t              cmd
);
  import gmde_pkg::*;

  typedef enum logic [19:0] {
    S_IDLE     = 20'h00001,
    S_RD       = 20'h00002,
    S_A_START  = 20'h00004,
    S_A_NODE   = 20'h00008,
    S_A_NODE_W = 20'h00010,
    S_A_L1     = 20'h00020,
    S_A_L1_W   = 20'h00040,
    S_A_NB_W   = 20'h00080,
    S_A_L2     = 20'h00100,
    S_A_L2_W   = 20'h00200,
    S_A_L2_M   = 20'h00400,
    S_B_START  = 20'h00800,
    S_B_NODE   = 20'h01000,
    S_B_NODE_W = 20'h02000,
    S_B_K      = 20'h04000,
    S_B_K_W    = 20'h08000,
    S_B_C_W    = 20'h10000,
    S_B_M      = 20'h20000,
    S_B_S      = 20'h40000,
    S_FIN      = 20'h80000
  } state_t;

  state_t state, state_next;
  logic   accept;
  func_t  func;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign func     = func_t'(s_tuser);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (func)
            FN_LOAD: cmd.ld_node = 1'b1;
            FN_LINK: cmd.ld_link = 1'b1;
            FN_RUN:  state_next = S_A_START;
            FN_READ: begin
              cmd.rd_flags = 1'b1;
              state_next   = S_RD;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_RD: begin
        if (!sts.out_full || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      // phase one: flag border nodes over the whole array
      S_A_START: begin
        cmd.i_clr   = 1'b1;
        cmd.cnt_clr = 1'b1;
        state_next  = S_A_NODE;
      end
      S_A_NODE: begin
        if (!sts.i_in) begin
          cmd.flag_wr = 1'b1;
          cmd.i_inc   = 1'b1;
          state_next  = sts.i_last ? S_B_START : S_A_NODE;
        end else begin
          state_next = S_A_NODE_W;
        end
      end
      S_A_NODE_W: begin
        cmd.cap_i = 1'b1;
        if (sts.q_marker) begin
          cmd.flag_wr   = 1'b1;
          cmd.flag_keep = 1'b1;
          cmd.i_inc     = 1'b1;
          state_next    = sts.i_last ? S_B_START : S_A_NODE;
        end else begin
          cmd.a_clr  = 1'b1;
          state_next = S_A_L1;
        end
      end
      S_A_L1: begin
        if (sts.a_done) begin
          cmd.flag_wr = 1'b1;
          cmd.i_inc   = 1'b1;
          state_next  = sts.i_last ? S_B_START : S_A_NODE;
        end else begin
          cmd.laddr_sel = LA_I;
          state_next    = S_A_L1_W;
        end
      end
      S_A_L1_W: begin
        cmd.naddr_sel = NA_LINK;
        state_next    = S_A_NB_W;
      end
      S_A_NB_W: begin
        cmd.cap_nb = 1'b1;
        cmd.b_clr  = 1'b1;
        if (sts.q_marker) begin
          cmd.flag_wr     = 1'b1;
          cmd.flag_border = 1'b1;
          cmd.blist_wr    = 1'b1;
          cmd.i_inc       = 1'b1;
          state_next      = sts.i_last ? S_B_START : S_A_NODE;
        end else begin
          state_next = S_A_L2;
        end
      end
      S_A_L2: begin
        if (sts.b_done) begin
          cmd.a_inc  = 1'b1;
          state_next = S_A_L1;
        end else begin
          cmd.laddr_sel = LA_NB;
          state_next    = S_A_L2_W;
        end
      end
      // keep the second-ring walk on the neighbour links so nb holds
      S_A_L2_W: begin
        cmd.laddr_sel = LA_NB;
        cmd.naddr_sel = NA_LINK;
        state_next    = S_A_L2_M;
      end
      S_A_L2_M: begin
        if (sts.q_marker) begin
          cmd.flag_wr     = 1'b1;
          cmd.flag_border = 1'b1;
          cmd.blist_wr    = 1'b1;
          cmd.i_inc       = 1'b1;
          state_next      = sts.i_last ? S_B_START : S_A_NODE;
        end else begin
          cmd.b_inc  = 1'b1;
          state_next = S_A_L2;
        end
      end
      // phase two: marked nodes against the border list
      S_B_START: begin
        cmd.i_clr  = 1'b1;
        state_next = S_B_NODE;
      end
      S_B_NODE: begin
        state_next = sts.i_in ? S_B_NODE_W : S_FIN;
      end
      S_B_NODE_W: begin
        cmd.cap_i = 1'b1;
        if (sts.q_marker) begin
          cmd.k_clr  = 1'b1;
          state_next = S_B_K;
        end else begin
          cmd.i_inc  = 1'b1;
          state_next = S_B_NODE;
        end
      end
      S_B_K: begin
        if (sts.k_done) begin
          cmd.i_inc  = 1'b1;
          state_next = S_B_NODE;
        end else begin
          state_next = S_B_K_W;
        end
      end
      S_B_K_W: begin
        cmd.naddr_sel = NA_BLIST;
        state_next    = S_B_C_W;
      end
      S_B_C_W: state_next = S_B_M;
      S_B_M:   state_next = S_B_S;
      S_B_S: begin
        if (sts.near) begin
          cmd.keep_clr = 1'b1;
          cmd.i_inc    = 1'b1;
          state_next   = S_B_NODE;
        end else begin
          cmd.k_inc  = 1'b1;
          state_next = S_B_K;
        end
      end
      S_FIN: begin
        cmd.ran_set = 1'b1;
        state_next  = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/gmde_dp.sv
// node, link and flag memories, counters and distance unit
`default_nettype none

module gmde_dp #(
  parameter int MAX_NODES      = gmde_pkg::MAX_NODES_DEF,
  parameter int MAX_NEIGHBOURS = gmde_pkg::MAX_NEIGHBOURS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic                           cfg_addr,
  input  wire logic [gmde_pkg::THR_W-1:0]     cfg_wdata,
  input  wire logic [gmde_pkg::IN_DATA_W-1:0] s_tdata,
  input  wire logic                           m_tready,
  output logic                                m_tvalid,
  output logic [gmde_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  wire gmde_pkg::cmd_t                 cmd,
  output gmde_pkg::sts_t                      sts
);
  import gmde_pkg::*;

  localparam int AW  = $clog2(MAX_NODES);
  localparam int IW  = AW + 1;
  localparam int SW  = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
  localparam int CW  = $clog2(MAX_NEIGHBOURS + 1);
  localparam int LAW = AW + SW;
  localparam int NW  = 1 + CW + 3 * COORD_W;
  localparam int DW  = COORD_W + 1;
  localparam int SQW = 2 * DW;
  localparam int SUMW = SQW + 2;

  // input fields
  logic [AW-1:0]       in_node, in_nidx;
  logic [COORD_W-1:0]  in_x, in_y, in_z;
  logic                in_mark;
  logic [NCOUNT_W-1:0] in_ncount;
  logic [SLOT_W-1:0]   in_slot;
  logic [CW-1:0]       cnt_sat;

  assign in_node   = AW'(s_tdata[IN_NODE_LSB +: IDX_W]);
  assign in_x      = s_tdata[IN_X_LSB +: COORD_W];
  assign in_y      = s_tdata[IN_Y_LSB +: COORD_W];
  assign in_z      = s_tdata[IN_Z_LSB +: COORD_W];
  assign in_mark   = s_tdata[IN_MARK_LSB];
  assign in_ncount = s_tdata[IN_NCOUNT_LSB +: NCOUNT_W];
  assign in_slot   = s_tdata[IN_SLOT_LSB +: SLOT_W];
  assign in_nidx   = AW'(s_tdata[IN_NIDX_LSB +: IDX_W]);
  assign cnt_sat   = (32'(in_ncount) > MAX_NEIGHBOURS) ? CW'(MAX_NEIGHBOURS) : CW'(in_ncount);

  // configuration registers
  logic [CNT_W-1:0] node_count;
  logic [THR_W-1:0] threshold_sq;
  logic [IW-1:0]    n_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count   <= CNT_W'(1024);
      threshold_sq <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_NODE_COUNT:   node_count   <= cfg_wdata[CNT_W-1:0];
        REG_THRESHOLD_SQ: threshold_sq <= cfg_wdata;
        default:          node_count   <= node_count;
      endcase
    end
  end

  assign n_sat = (32'(node_count) > MAX_NODES) ? IW'(MAX_NODES) : IW'(node_count);

  // walk counters
  logic [IW-1:0] i, k, bc, cl;
  logic [CW-1:0] a, b, ci, cb;
  logic [AW-1:0] nb, i_addr;
  logic          ran;

  assign i_addr = i[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      i   <= '0;
      k   <= '0;
      a   <= '0;
      b   <= '0;
      bc  <= '0;
      cl  <= '0;
      ran <= 1'b0;
    end else begin
      if (cmd.i_clr) i <= '0;
      else if (cmd.i_inc) i <= i + 1'b1;
      if (cmd.k_clr) k <= '0;
      else if (cmd.k_inc) k <= k + 1'b1;
      if (cmd.a_clr) a <= '0;
      else if (cmd.a_inc) a <= a + 1'b1;
      if (cmd.b_clr) b <= '0;
      else if (cmd.b_inc) b <= b + 1'b1;
      if (cmd.cnt_clr) begin
        bc <= '0;
        cl <= '0;
      end else begin
        if (cmd.blist_wr) bc <= bc + 1'b1;
        if (cmd.keep_clr) cl <= cl + 1'b1;
      end
      if (cmd.ran_set) ran <= 1'b1;
    end
  end

  // node memory: marker, link count, coordinates
  logic [NW-1:0]      node_mem [MAX_NODES];
  logic [NW-1:0]      node_q;
  logic [AW-1:0]      node_raddr;
  logic [LAW-1:0]     link_raddr;
  logic [AW-1:0]      link_mem [MAX_NODES << SW];
  logic [AW-1:0]      link_q;
  logic [AW-1:0]      blist_mem [MAX_NODES];
  logic [AW-1:0]      blist_q;
  logic               link_we;

  assign link_we = cmd.ld_link && (32'(in_slot) < MAX_NEIGHBOURS);

  always_comb begin
    unique case (cmd.naddr_sel)
      NA_I:     node_raddr = i_addr;
      NA_LINK:  node_raddr = link_q;
      NA_BLIST: node_raddr = blist_q;
      default:  node_raddr = i_addr;
    endcase
  end

  assign link_raddr = (cmd.laddr_sel == LA_NB) ? {nb, SW'(b)} : {i_addr, SW'(a)};

  always_ff @(posedge clk) begin
    if (cmd.ld_node) node_mem[in_node] <= {in_mark, cnt_sat, in_z, in_y, in_x};
    node_q <= node_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[{in_node, SW'(in_slot)}] <= in_nidx;
    link_q <= link_mem[link_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.blist_wr) blist_mem[bc[AW-1:0]] <= i_addr;
    blist_q <= blist_mem[k[AW-1:0]];
  end

  logic                q_mark;
  logic [CW-1:0]       q_cnt;
  logic [COORD_W-1:0]  q_x, q_y, q_z;

  assign q_x    = node_q[0 +: COORD_W];
  assign q_y    = node_q[COORD_W +: COORD_W];
  assign q_z    = node_q[2*COORD_W +: COORD_W];
  assign q_cnt  = node_q[3*COORD_W +: CW];
  assign q_mark = node_q[NW-1];

  // captured node and neighbour data
  logic [COORD_W-1:0] xi, yi, zi;

  always_ff @(posedge clk) begin
    if (cmd.cap_i) begin
      ci <= q_cnt;
      xi <= q_x;
      yi <= q_y;
      zi <= q_z;
    end
    if (cmd.cap_nb) cb <= q_cnt;
    if (cmd.laddr_sel == LA_I && cmd.naddr_sel == NA_LINK && !cmd.cap_nb) nb <= link_q;
  end

  // distance unit: differences, squares, sum and compare
  function automatic logic [DW-1:0] mag_diff(input logic [COORD_W-1:0] p,
                                             input logic [COORD_W-1:0] q);
    logic [DW-1:0] d;
    d = {p[COORD_W-1], p} - {q[COORD_W-1], q};
    return d[DW-1] ? (~d + 1'b1) : d;
  endfunction

  logic [DW-1:0]   dx, dy, dz;
  logic [SQW-1:0]  sx, sy, sz;
  logic [SUMW-1:0] sq_sum;

  always_ff @(posedge clk) begin
    dx <= mag_diff(xi, q_x);
    dy <= mag_diff(yi, q_y);
    dz <= mag_diff(zi, q_z);
    sx <= SQW'(dx) * SQW'(dx);
    sy <= SQW'(dy) * SQW'(dy);
    sz <= SQW'(dz) * SQW'(dz);
  end

  assign sq_sum = SUMW'(sx) + SUMW'(sy) + SUMW'(sz);

  // result flags
  logic keep_mem [MAX_NODES];
  logic bord_mem [MAX_NODES];
  logic keep_q, bord_q;
  logic [IDX_W-1:0] rd_node;

  always_ff @(posedge clk) begin
    if (cmd.flag_wr) begin
      keep_mem[i_addr] <= cmd.flag_keep;
      bord_mem[i_addr] <= cmd.flag_border;
    end else if (cmd.keep_clr) begin
      keep_mem[i_addr] <= 1'b0;
    end
    if (cmd.rd_flags) begin
      keep_q  <= keep_mem[in_node];
      bord_q  <= bord_mem[in_node];
      rd_node <= IDX_W'(in_node);
    end
  end

  // output register
  logic [IDX_W-1:0] out_node;
  logic             out_keep, out_bord;
  logic [CNT_W-1:0] out_bt, out_ct;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_node <= rd_node;
      out_keep <= ran & keep_q;
      out_bord <= ran & bord_q;
      out_bt   <= CNT_W'(bc);
      out_ct   <= CNT_W'(cl);
    end
  end

  assign m_tdata = OUT_DATA_W'({out_ct, out_bt, out_bord, out_keep, out_node});

  // status back to the sequencer
  assign sts.i_in     = (i < n_sat);
  assign sts.i_last   = (i == IW'(MAX_NODES - 1));
  assign sts.a_done   = (a >= ci);
  assign sts.b_done   = (b >= cb);
  assign sts.k_done   = (k >= bc);
  assign sts.q_marker = q_mark;
  assign sts.near     = (sq_sum < SUMW'(threshold_sq));
  assign sts.out_full = m_tvalid;

endmodule

`default_nettype wire

>>> rtl/graph_marker_distance_erosion.sv
// top level of the graph marker distance erosion block
`default_nettype none

// Load-node and load-link transactions are taken in the idle state and may
// follow back to back; a read waits in the read state for the output side.
// A run walks every array entry once to find border nodes: entries beyond
// node_count get both flags written low, marked nodes are kept, and for each
// unmarked node the first-ring links are followed and the second-ring links
// looked at (a marked neighbour ends the node early). It then walks the nodes
// in range and compares each marked node with the border nodes in turn,
// stopping early at the first near border node. The node memory has a
// single read port, shared by the link walk and the distance unit. Result
// flags read as zero until the first run; no clearing pass.
module graph_marker_distance_erosion #(
  parameter int MAX_NODES      = gmde_pkg::MAX_NODES_DEF,
  parameter int MAX_NEIGHBOURS = gmde_pkg::MAX_NEIGHBOURS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic                           cfg_addr,
  input  wire logic [gmde_pkg::THR_W-1:0]     cfg_wdata,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // node_index, x_coord, y_coord, z_coord, marker, neighbor_count,
  // neighbor_slot, neighbor_index
  input  wire logic [gmde_pkg::IN_DATA_W-1:0] s_tdata,
  // func
  input  wire logic [gmde_pkg::FUNC_W-1:0]    s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // result_node, keep, is_border, border_total, cleared_total
  output logic [gmde_pkg::OUT_DATA_W-1:0]     m_tdata
);
  import gmde_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gmde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gmde_dp #(
    .MAX_NODES      (MAX_NODES),
    .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

`ifndef SYNTHESIS
  // a result is never loaded over one that is still waiting
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result register overwritten");

  // one write per cycle into the keep flags
  a_keep_wr: assert property (@(posedge clk) disable iff (rst)
    cmd.flag_wr |-> !cmd.keep_clr)
    else $error("keep flag write conflict");

  // a run transaction holds off further input
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == FN_RUN) |=> !s_tready)
    else $error("input accepted during run");
`endif

endmodule

`default_nettype wire
